// ===== hdl/bed_pkg.sv =====
// Package for the backslash escape decoder: decoder phase, input mode codes,
// byte constants and the queue entry that links the front and back parts.
// No dependencies.
`default_nettype none
package bed_pkg;

  typedef enum logic [4:0] {
    PH_NORMAL    = 5'b00001,
    PH_BACKSLASH = 5'b00010,
    PH_OCTAL     = 5'b00100,
    PH_HEX       = 5'b01000,
    PH_STOPPED   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_SEP  = 2'd1,
    MODE_END  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam logic REG_ESCAPES_ENABLED  = 1'b0;
  localparam logic REG_SUPPRESS_NEWLINE = 1'b1;

  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] BYTE_ESC       = 8'h1B;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;

  // One accepted item's output: one byte, or two when two is set.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/bed_front.sv =====
// Front part of the escape decoder: holds the configuration registers and
// the decoder state, classifies each input beat and pushes its bytes.
// Depends on bed_pkg.
`default_nettype none
module bed_front
  import bed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] ch,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       q_full,
  output logic            push,
  output entry_t          push_data
);

  logic       escapes_enabled;
  logic       suppress_newline;
  phase_t     phase, phase_next;
  logic [7:0] accumulator, accumulator_next;
  logic [1:0] digits_taken, digits_taken_next;

  logic       take;
  logic [1:0] cnt;
  logic [7:0] b0, b1;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  always_comb begin
    logic       is_octal;
    logic       is_digit;
    logic [3:0] dval;
    logic [7:0] hex_tmp;
    logic [7:0] acc_shift;
    logic [1:0] dig_inc;
    logic       done;
    logic       pending;
    logic [7:0] pend_byte;

    phase_next        = phase;
    accumulator_next  = accumulator;
    digits_taken_next = digits_taken;
    cnt               = 2'd0;
    b0                = '0;
    b1                = '0;

    is_octal = (phase == PH_OCTAL);
    hex_tmp  = '0;
    if (is_octal) begin
      is_digit = (ch >= "0") && (ch <= "7");
      dval     = {1'b0, ch[2:0]};
    end else begin
      is_digit = 1'b1;
      if ((ch >= "0") && (ch <= "9")) begin
        hex_tmp = ch - 8'h30;
      end else if ((ch >= "A") && (ch <= "F")) begin
        hex_tmp = ch - 8'h37;
      end else if ((ch >= "a") && (ch <= "f")) begin
        hex_tmp = ch - 8'h57;
      end else begin
        is_digit = 1'b0;
      end
      dval = hex_tmp[3:0];
    end
    acc_shift = is_octal ? {accumulator[4:0], dval[2:0]} : {accumulator[3:0], dval};
    dig_inc   = digits_taken + 2'd1;
    done      = is_octal ? (dig_inc == 2'd3) : (dig_inc == 2'd2);

    pending   = (phase == PH_BACKSLASH) || (phase == PH_OCTAL) || (phase == PH_HEX);
    pend_byte = (phase == PH_BACKSLASH) ? BYTE_BACKSLASH : accumulator;

    unique case (mode)
      MODE_CHAR: begin
        unique case (phase)
          PH_NORMAL: begin
            if (escapes_enabled && (ch == BYTE_BACKSLASH)) begin
              phase_next = PH_BACKSLASH;
            end else begin
              cnt = 2'd1;
              b0  = ch;
            end
          end
          PH_BACKSLASH: begin
            phase_next = PH_NORMAL;
            cnt        = 2'd1;
            b0         = ch;
            case (ch)
              "a": b0 = 8'h07;
              "b": b0 = 8'h08;
              "e": b0 = BYTE_ESC;
              "f": b0 = 8'h0C;
              "n": b0 = 8'h0A;
              "r": b0 = 8'h0D;
              "t": b0 = 8'h09;
              "v": b0 = 8'h0B;
              "c": begin
                cnt        = 2'd0;
                phase_next = PH_STOPPED;
              end
              "0": begin
                cnt               = 2'd0;
                phase_next        = PH_OCTAL;
                accumulator_next  = '0;
                digits_taken_next = '0;
              end
              "x": begin
                cnt               = 2'd0;
                phase_next        = PH_HEX;
                accumulator_next  = '0;
                digits_taken_next = '0;
              end
              default: ;
            endcase
          end
          PH_OCTAL, PH_HEX: begin
            if (!is_digit) begin
              // close the number, then handle the character as in the normal phase
              b0                = accumulator;
              accumulator_next  = '0;
              digits_taken_next = '0;
              if (escapes_enabled && (ch == BYTE_BACKSLASH)) begin
                phase_next = PH_BACKSLASH;
                cnt        = 2'd1;
              end else begin
                phase_next = PH_NORMAL;
                cnt        = 2'd2;
                b1         = ch;
              end
            end else if (done) begin
              cnt               = 2'd1;
              b0                = acc_shift;
              accumulator_next  = '0;
              digits_taken_next = '0;
              phase_next        = PH_NORMAL;
            end else begin
              accumulator_next  = acc_shift;
              digits_taken_next = dig_inc;
            end
          end
          PH_STOPPED: ;
          default: ;
        endcase
      end
      MODE_SEP: begin
        if (phase != PH_STOPPED) begin
          phase_next        = PH_NORMAL;
          accumulator_next  = '0;
          digits_taken_next = '0;
          if (pending) begin
            cnt = 2'd2;
            b0  = pend_byte;
            b1  = BYTE_SPACE;
          end else begin
            cnt = 2'd1;
            b0  = BYTE_SPACE;
          end
        end
      end
      MODE_END: begin
        phase_next        = PH_NORMAL;
        accumulator_next  = '0;
        digits_taken_next = '0;
        if (phase != PH_STOPPED) begin
          if (pending) begin
            b0 = pend_byte;
            if (!suppress_newline) begin
              cnt = 2'd2;
              b1  = BYTE_NEWLINE;
            end else begin
              cnt = 2'd1;
            end
          end else if (!suppress_newline) begin
            cnt = 2'd1;
            b0  = BYTE_NEWLINE;
          end
        end
      end
      MODE_NONE: ;
      default: ;
    endcase
  end

  assign push         = take && (cnt != 2'd0);
  assign push_data.two = (cnt == 2'd2);
  assign push_data.b0  = b0;
  assign push_data.b1  = b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escapes_enabled  <= 1'b0;
      suppress_newline <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ESCAPES_ENABLED:  escapes_enabled  <= cfg_data;
        REG_SUPPRESS_NEWLINE: suppress_newline <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NORMAL;
      accumulator  <= '0;
      digits_taken <= '0;
    end else if (take) begin
      phase        <= phase_next;
      accumulator  <= accumulator_next;
      digits_taken <= digits_taken_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bed_queue.sv =====
// Short queue of decoded entries between the front and back parts.
// Depends on bed_pkg.
`default_nettype none
module bed_queue
  import bed_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  entry_t      push_data,
  output logic        full,
  input  wire logic   pop,
  output entry_t      pop_data,
  output logic        empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bed_back.sv =====
// Back part of the escape decoder: takes entries from the queue and sends
// their bytes out one beat at a time from an output register.
// Depends on bed_pkg.
`default_nettype none
module bed_back
  import bed_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  entry_t      q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);

  entry_t cur;
  logic   cur_valid;
  logic   second;
  logic   finishing;

  assign last_of_run = second || !cur.two;
  assign out_byte    = second ? cur.b1 : cur.b0;
  assign out_valid   = cur_valid;
  assign finishing   = cur_valid && out_ready && last_of_run;
  assign q_pop       = !q_empty && (!cur_valid || finishing);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (cur_valid && out_ready && !last_of_run) begin
      // advance to the second byte of the run
      second <= 1'b1;
    end else if (!cur_valid || finishing) begin
      cur_valid <= q_pop;
      second    <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/backslash_escape_decoder.sv =====
// Path: the first result beat of an input beat is written into the queue and then
// loaded into the output register, from which it can be taken.
// Throughput: one input beat per cycle while the queue has room; an item that
// yields two bytes holds the output until both are taken, the QUEUE_DEPTH-entry queue
// absorbs short bursts of those, and the input stalls whenever the queue is full.
// Reset clears the configuration registers, the decoder state and the queue.
// Depends on bed_pkg, bed_front, bed_queue and bed_back.
`default_nettype none
module backslash_escape_decoder
  import bed_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] ch,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data
);

  logic   push, q_full, q_pop, q_empty;
  entry_t push_data, q_data;

  bed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .ch        (ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  bed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire
